/* sv/lcr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the line column rasterizer.
// No dependencies; imported by every module of the block.
package lcr_pkg;

    localparam int WIDTH  = 1024;
    localparam int HEIGHT = 768;

    localparam int COORD_W = 13;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int QUOT_W  = COORD_W;
    localparam int REM_W   = 2 * COORD_W;
    localparam int CNT_W   = $clog2(QUOT_W);
    localparam int XPIX_W  = $clog2(WIDTH - 1);
    localparam int YPIX_W  = $clog2(HEIGHT - 1);
    localparam int DEPTH_W = 6;
    localparam int STRIDE_W = 16;
    localparam int BPP_W   = 4;
    localparam int OFFS_W  = 32;
    localparam int COLOUR_W = 24;
    localparam int CHK_W   = 16;

    localparam logic [COLOUR_W-1:0] COLOUR_BASE = 24'hffff00;
    localparam logic [COLOUR_W-1:0] COLOUR_STEP = 24'h003000;

    localparam logic signed [COORD_W-1:0] X_STOP = COORD_W'(WIDTH);
    localparam logic signed [CHK_W-1:0]   X_MAX  = CHK_W'(WIDTH - 2);
    localparam logic signed [CHK_W-1:0]   Y_MAX  = CHK_W'(HEIGHT - 2);

    // Register map, indexed by paddr[2]
    localparam logic REG_STRIDE = 1'b0;
    localparam logic REG_BPP    = 1'b1;

    // Stamp point order
    localparam logic [2:0] PT_CENTRE = 3'd0;
    localparam logic [2:0] PT_UP     = 3'd1;
    localparam logic [2:0] PT_DOWN   = 3'd2;
    localparam logic [2:0] PT_LEFT   = 3'd3;
    localparam logic [2:0] PT_RIGHT  = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_COLS = 2'd1,
        MODE_ROWS = 2'd2
    } walk_mode_t;

    typedef enum logic [1:0] {
        T_IDLE  = 2'd0,
        T_DIV   = 2'd1,
        T_STAMP = 2'd2
    } top_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE = 2'd0,
        DIV_MUL  = 2'd1,
        DIV_RUN  = 2'd2,
        DIV_DONE = 2'd3
    } div_state_t;

    typedef enum logic [1:0] {
        STP_IDLE = 2'd0,
        STP_BASE = 2'd1,
        STP_SEND = 2'd2
    } stamp_state_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] xoff;
        logic signed [DIFF_W-1:0] dx;
    } div_req_t;

    typedef struct packed {
        logic                draw;
        logic                line_done;
        logic [DEPTH_W-1:0]  depth;
        logic [XPIX_W-1:0]   cx;
        logic [YPIX_W-1:0]   cy;
    } stamp_req_t;

    function automatic logic lcr_in_frame(input logic signed [CHK_W-1:0] x,
                                          input logic signed [CHK_W-1:0] y);
        return (x >= 16'sd1) && (x <= X_MAX) && (y >= 16'sd1) && (y <= Y_MAX);
    endfunction

endpackage

/* sv/lcr_divider.sv */
`timescale 1ns / 1ps
// Multiply then divide unit: a multiply step, then one restoring
// compare-subtract per quotient bit. Depends on lcr_pkg.
module lcr_divider
    import lcr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  div_req_t                 req,
    output logic                     done,
    output logic signed [DIFF_W-1:0] quotient
);

    div_state_t               state_reg, state_next;
    logic signed [DIFF_W-1:0] a_reg, a_next;
    logic signed [DIFF_W-1:0] b_reg, b_next;
    logic signed [DIFF_W-1:0] d_reg, d_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [REM_W-1:0]         dsh_reg, dsh_next;
    logic [QUOT_W-1:0]        q_reg, q_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: if (start) state_next = DIV_MUL;
            DIV_MUL:  state_next = DIV_RUN;
            DIV_RUN:  if (cnt_reg == CNT_W'(QUOT_W - 1)) state_next = DIV_DONE;
            DIV_DONE: state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    always_comb
    begin
        logic signed [PROD_W-1:0] prod;
        logic [PROD_W-1:0]        pmag;
        logic [DIFF_W-1:0]        dmag;
        a_next   = a_reg;
        b_next   = b_reg;
        d_next   = d_reg;
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        prod = a_reg * b_reg;
        pmag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        dmag = d_reg[DIFF_W-1] ? DIFF_W'(-d_reg) : DIFF_W'(d_reg);
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    a_next = req.dy;
                    b_next = req.xoff;
                    d_next = req.dx;
                end
            end
            DIV_MUL:
            begin
                // |product| < |divisor| * 2^QUOT_W, so QUOT_W steps suffice
                rem_next = pmag[REM_W-1:0];
                dsh_next = REM_W'(dmag) << (QUOT_W - 1);
                neg_next = prod[PROD_W-1] ^ d_reg[DIFF_W-1];
                q_next   = '0;
                cnt_next = '0;
            end
            DIV_RUN:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    q_next   = {q_reg[QUOT_W-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        done     = (state_reg == DIV_DONE);
        quotient = neg_reg ? -$signed(DIFF_W'(q_reg)) : $signed(DIFF_W'(q_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

endmodule

/* sv/lcr_stamp.sv */
`timescale 1ns / 1ps
// Stamp emitter: turns one point into the five plus-shaped pixel writes,
// or one invalid result, on the master stream. Depends on lcr_pkg.
module lcr_stamp
    import lcr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  stamp_req_t          req,
    input  logic [STRIDE_W-1:0] stride,
    input  logic [BPP_W-1:0]    bpp,
    output logic                done,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata,   // byte_offset[31:0], pixel_colour[55:32]
    output logic [1:0]          m_tuser,   // write_valid[0], line_done[1]
    output logic                m_tlast
);

    stamp_state_t          state_reg, state_next;
    stamp_req_t            req_reg;
    logic [COLOUR_W-1:0]   colour_reg;
    logic [OFFS_W-1:0]     base_reg;
    logic [2:0]            pt_reg, pt_next;
    logic [OFFS_W-1:0]     offset;
    logic                  final_pt;

    assign final_pt = !req_reg.draw || (pt_reg == PT_RIGHT);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            STP_IDLE: if (start) state_next = STP_BASE;
            STP_BASE: state_next = STP_SEND;
            STP_SEND: if (m_tready && final_pt) state_next = STP_IDLE;
            default:  state_next = STP_IDLE;
        endcase
    end

    always_comb
    begin
        pt_next = pt_reg;
        if (state_reg == STP_BASE)
            pt_next = PT_CENTRE;
        else if (state_reg == STP_SEND && m_tready && !final_pt)
            pt_next = pt_reg + 3'd1;
    end

    always_comb
    begin
        case (pt_reg)
            PT_CENTRE: offset = base_reg;
            PT_UP:     offset = base_reg - OFFS_W'(stride);
            PT_DOWN:   offset = base_reg + OFFS_W'(stride);
            PT_LEFT:   offset = base_reg - OFFS_W'(bpp);
            PT_RIGHT:  offset = base_reg + OFFS_W'(bpp);
            default:   offset = base_reg;
        endcase
    end

    always_comb
    begin
        m_tvalid = (state_reg == STP_SEND);
        m_tlast  = final_pt;
        m_tuser  = {req_reg.line_done, req_reg.draw};
        m_tdata  = req_reg.draw ? {colour_reg, offset} : '0;
        done     = (state_reg == STP_SEND) && m_tready && final_pt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STP_IDLE;
            pt_reg    <= PT_CENTRE;
        end
        else
        begin
            state_reg <= state_next;
            pt_reg    <= pt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == STP_IDLE && start)
        begin
            req_reg    <= req;
            colour_reg <= COLOUR_BASE - COLOUR_W'(req.depth) * COLOUR_STEP;
        end
        if (state_reg == STP_BASE)
            base_reg <= OFFS_W'(req_reg.cy) * OFFS_W'(stride)
                      + OFFS_W'(req_reg.cx) * OFFS_W'(bpp);
    end

endmodule

/* sv/line_column_rasterizer_top.sv */
`timescale 1ns / 1ps
// Top level of the line column rasterizer: line state, walk sequencer,
// register port. Depends on lcr_pkg, lcr_divider and lcr_stamp.
//
// Usage:
//   Slave stream (s_*) carries commands: s_tuser[0] = 0 loads a line from
//   s_tdata (end points and depth), s_tuser[0] = 1 steps the walk by one
//   column (or one row for a vertical line). A load gives no output.
//   Master stream (m_*) carries pixel writes: each step yields five writes
//   (centre, up, down, left, right) or a single write with write_valid low
//   when the point is clipped or no line is active; m_tlast closes the group.
//   The APB port holds the row stride (0x0) and bytes per pixel (0x4); write
//   it only while the block is idle.
// Sequencing:
//   One command is in flight at a time; s_tready is high only while idle.
//   A load leaves the block idle. A column step runs through the accept,
//   a multiply, one compare-subtract per quotient bit and a result state
//   in the divider, a frame offset state, then the output writes. A row or
//   idle step skips the divider: accept, frame offset, output writes.
//   A stalled receiver (m_tready low) holds the current write on m_* and
//   the block accepts nothing until the last write of the group is taken.
//   Reset clears the line to idle, stride to 4096 and bytes per pixel to 4.
module line_column_rasterizer_top
    import lcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_start[12:0], y_start[25:13], x_end[38:26],
                                   // y_end[51:39], depth[57:52], zero[63:58]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // byte_offset[31:0], pixel_colour[55:32]
    output logic [1:0]  m_tuser,   // write_valid[0], line_done[1]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    top_state_t                state_reg, state_next;
    walk_mode_t                mode_reg, mode_next;
    logic signed [COORD_W-1:0] start_x_reg, start_x_next;
    logic signed [COORD_W-1:0] start_y_reg, start_y_next;
    logic signed [COORD_W-1:0] end_x_reg, end_x_next;
    logic signed [COORD_W-1:0] end_y_reg, end_y_next;
    logic [DEPTH_W-1:0]        depth_reg, depth_next;
    logic signed [COORD_W-1:0] walk_reg, walk_next;
    logic signed [COORD_W-1:0] cur_x_reg, cur_x_next;
    logic                      done_reg, done_next;
    logic [STRIDE_W-1:0]       stride_reg;
    logic [BPP_W-1:0]          bpp_reg;

    logic                      accept;
    logic                      cfg_write;
    logic                      div_start;
    div_req_t                  div_req;
    logic                      div_done;
    logic signed [DIFF_W-1:0]  div_quot;
    logic                      stamp_start;
    stamp_req_t                stamp_req;
    logic                      stamp_done;
    logic                      goto_div;

    assign accept    = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    // Register port
    always_comb
    begin
        pready = 1'b1;
        case (paddr[2])
            REG_STRIDE: prdata = 32'(stride_reg);
            REG_BPP:    prdata = 32'(bpp_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= 16'd4096;
            bpp_reg    <= 4'd4;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_STRIDE: stride_reg <= pwdata[STRIDE_W-1:0];
                REG_BPP:    bpp_reg    <= pwdata[BPP_W-1:0];
                default:    stride_reg <= stride_reg;
            endcase
        end
    end

    // Walk datapath: load, step decode and stamp requests
    always_comb
    begin
        logic signed [COORD_W-1:0] sx, sy, ex, ey;
        logic signed [COORD_W-1:0] lo, hi, stop, ystop;
        logic signed [DIFF_W+0:0]  ycol;
        sx = s_tdata[12:0];
        sy = s_tdata[25:13];
        ex = s_tdata[38:26];
        ey = s_tdata[51:39];
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        end_x_next   = end_x_reg;
        end_y_next   = end_y_reg;
        depth_next   = depth_reg;
        walk_next    = walk_reg;
        mode_next    = mode_reg;
        cur_x_next   = cur_x_reg;
        done_next    = done_reg;
        goto_div     = 1'b0;
        div_start    = 1'b0;
        stamp_start  = 1'b0;
        stamp_req    = '0;
        stamp_req.depth = depth_reg;
        div_req.dy   = DIFF_W'(end_y_reg) - DIFF_W'(start_y_reg);
        div_req.xoff = DIFF_W'(walk_reg) - DIFF_W'(start_x_reg);
        div_req.dx   = DIFF_W'(end_x_reg) - DIFF_W'(start_x_reg);
        lo    = (start_x_reg < end_x_reg) ? start_x_reg : end_x_reg;
        hi    = (start_x_reg > end_x_reg) ? start_x_reg : end_x_reg;
        stop  = (hi < X_STOP) ? hi : X_STOP;
        ystop = (start_y_reg > end_y_reg) ? start_y_reg : end_y_reg;
        ycol  = (DIFF_W+1)'(div_quot) + (DIFF_W+1)'(start_y_reg);

        if (state_reg == T_IDLE && accept)
        begin
            if (!s_tuser[0])
            begin
                // Load: latch the line and drop any walk in progress
                start_x_next = sx;
                start_y_next = sy;
                end_x_next   = ex;
                end_y_next   = ey;
                depth_next   = s_tdata[57:52];
                if (sx == ex)
                begin
                    mode_next = MODE_ROWS;
                    walk_next = (sy < ey) ? sy : ey;
                end
                else
                begin
                    mode_next = MODE_COLS;
                    lo = (sx < ex) ? sx : ex;
                    walk_next = (lo > 13'sd1) ? lo : 13'sd1;
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_COLS:
                    begin
                        if (walk_reg > stop)
                        begin
                            // Span misses the columns: one idle result
                            mode_next       = MODE_IDLE;
                            stamp_start     = 1'b1;
                            stamp_req.line_done = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            goto_div   = 1'b1;
                            cur_x_next = walk_reg;
                            done_next  = (walk_reg == stop);
                            if (walk_reg == stop)
                                mode_next = MODE_IDLE;
                            else
                                walk_next = walk_reg + 13'sd1;
                        end
                    end
                    MODE_ROWS:
                    begin
                        stamp_start         = 1'b1;
                        stamp_req.draw      = lcr_in_frame(CHK_W'(start_x_reg),
                                                           CHK_W'(walk_reg));
                        stamp_req.line_done = (walk_reg >= ystop);
                        stamp_req.cx        = start_x_reg[XPIX_W-1:0];
                        stamp_req.cy        = walk_reg[YPIX_W-1:0];
                        if (walk_reg >= ystop)
                            mode_next = MODE_IDLE;
                        else
                            walk_next = walk_reg + 13'sd1;
                    end
                    default:
                    begin
                        stamp_start         = 1'b1;
                        stamp_req.line_done = 1'b1;
                    end
                endcase
            end
        end
        else if (state_reg == T_DIV && div_done)
        begin
            stamp_start         = 1'b1;
            stamp_req.draw      = lcr_in_frame(CHK_W'(cur_x_reg), CHK_W'(ycol));
            stamp_req.line_done = done_reg;
            stamp_req.cx        = cur_x_reg[XPIX_W-1:0];
            stamp_req.cy        = ycol[YPIX_W-1:0];
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (goto_div)
                    state_next = T_DIV;
                else if (stamp_start)
                    state_next = T_STAMP;
            end
            T_DIV:   if (div_done) state_next = T_STAMP;
            T_STAMP: if (stamp_done) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready = (state_reg == T_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            mode_reg    <= MODE_IDLE;
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            depth_reg   <= '0;
            walk_reg    <= '0;
            cur_x_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            end_x_reg   <= end_x_next;
            end_y_reg   <= end_y_next;
            depth_reg   <= depth_next;
            walk_reg    <= walk_next;
            cur_x_reg   <= cur_x_next;
            done_reg    <= done_next;
        end
    end

    lcr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    lcr_stamp u_stamp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (stamp_start),
        .req      (stamp_req),
        .stride   (stride_reg),
        .bpp      (bpp_reg),
        .done     (stamp_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // No output transaction may be pending while a new command is taken
    a_idle_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("output pending while accepting commands");

    // A clipped or idle result stands alone
    a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("invalid result not marked last");

    // Divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == T_DIV))
        else $error("divider result outside of a column step");

    // A load leaves the block ready in the next cycle
    a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser[0]) |=> s_tready)
        else $error("load transaction did not return to idle");

endmodule
